### hw/rtl/nure_pkg.sv
// shared widths and byte codes for the ndef uri record extractor
// no dependencies; used by the channel interfaces, the core and its checker
`default_nettype none

package nure_pkg;

    localparam int LENGTH_BITS_DEF = 16;  // buffer length field width
    localparam int BYTE_W          = 8;
    localparam int CAP_W           = 9;   // url capacity register
    localparam int MSG_W           = 16;  // ndef message length
    localparam int SUM_W           = MSG_W + 1;
    localparam int POS_W           = 10;  // bytes left to skip in a record

    localparam logic [CAP_W-1:0]  CAP_RESET      = 9'd256;
    localparam logic [CAP_W-1:0]  CAP_MIN        = 9'd2;
    localparam logic [BYTE_W-1:0] TLV_NDEF       = 8'h03;
    localparam logic [BYTE_W-1:0] LEN_LONG_MARK  = 8'hFF;
    localparam logic [2:0]        TNF_MASK       = 3'h7;
    localparam logic [2:0]        TNF_WELL_KNOWN = 3'h1;
    localparam logic [BYTE_W-1:0] TYPE_URI       = 8'h55;  // 'U'
    localparam int                SHORT_HDR      = 2;      // type byte + short length
    localparam int                LONG_HDR       = 4;      // type byte + 0xff + two bytes
    localparam int                MIN_RECORD     = 3;      // flags, type len, payload len

endpackage

`default_nettype wire

### hw/rtl/nure_in_if.sv
// input channel: one tag buffer byte per word, valid/ready handshake
// depends on nure_pkg for the field widths
`default_nettype none

interface nure_in_if #(
    parameter int LEN_W = nure_pkg::LENGTH_BITS_DEF
);
    logic                        valid;
    logic                        ready;
    logic [nure_pkg::BYTE_W-1:0] data_byte;
    logic                        first_byte;
    logic [LEN_W-1:0]            buffer_length;

    modport source (output valid, output data_byte, output first_byte,
                    output buffer_length, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input buffer_length, output ready);
endinterface

`default_nettype wire

### hw/rtl/nure_out_if.sv
// output channel: one url byte or one error word, valid/ready handshake
// depends on nure_pkg for the field widths
`default_nettype none

interface nure_out_if;
    logic                        valid;
    logic                        ready;
    logic [nure_pkg::BYTE_W-1:0] url_byte;
    logic                        last;
    logic                        ok;
    logic [nure_pkg::BYTE_W-1:0] url_length;

    modport source (output valid, output url_byte, output last, output ok,
                    output url_length, input ready);
    modport sink   (input valid, input url_byte, input last, input ok,
                    input url_length, output ready);
endinterface

`default_nettype wire

### hw/rtl/ndef_uri_record_extractor_core.sv
// Takes a tag buffer one byte per word, parses the NDEF TLV header and walks
// short-format records; the URL of the first well-known 'U' record comes out
// one byte per word, ending with last and the URL length, and any failure
// gives a single error word. Throughput is one byte per clock: each byte goes
// through an input register, one pass of compare and count logic against the
// parse state, and an output register, so a byte is accepted every cycle while
// the output is taken or while the byte gives no word. url_capacity is written
// through i_cfg_we/i_cfg_wdata; the user must do so only while no buffer is in
// flight, since the block itself does not enforce this.
// Depends on nure_pkg, nure_in_if and nure_out_if.
`default_nettype none

module ndef_uri_record_extractor_core #(
    parameter int LENGTH_BITS = nure_pkg::LENGTH_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [nure_pkg::CAP_W-1:0] i_cfg_wdata,
    nure_in_if.sink                    i_in,
    nure_out_if.source                 o_out
);
    import nure_pkg::*;

    typedef enum logic [11:0] {
        PH_WAIT    = 12'b0000_0000_0001,
        PH_LEN1    = 12'b0000_0000_0010,
        PH_LONG_HI = 12'b0000_0000_0100,
        PH_LONG_LO = 12'b0000_0000_1000,
        PH_FLAGS   = 12'b0000_0001_0000,
        PH_TLEN    = 12'b0000_0010_0000,
        PH_PLEN    = 12'b0000_0100_0000,
        PH_TYPE    = 12'b0000_1000_0000,
        PH_CODE    = 12'b0001_0000_0000,
        PH_URL     = 12'b0010_0000_0000,
        PH_SKIP    = 12'b0100_0000_0000,
        PH_DONE    = 12'b1000_0000_0000
    } t_phase;

    // configuration
    logic [CAP_W-1:0]       r_capacity;

    // input stage
    logic                   r_in_valid;
    logic [BYTE_W-1:0]      r_in_byte;
    logic                   r_in_first;
    logic [LENGTH_BITS-1:0] r_in_len;

    // parse state
    t_phase                 r_phase,  n_phase;
    logic [LENGTH_BITS-1:0] r_bufsz,  n_bufsz;
    logic [MSG_W-1:0]       r_msglen, n_msglen;
    logic [MSG_W-1:0]       r_taken,  n_taken;
    logic [2:0]             r_tnf,    n_tnf;
    logic [BYTE_W-1:0]      r_tlen,   n_tlen;
    logic [BYTE_W-1:0]      r_plen,   n_plen;
    logic [POS_W-1:0]       r_pos,    n_pos;
    logic [BYTE_W-1:0]      r_sent,   n_sent;

    // output stage
    logic                   r_out_valid;
    logic [BYTE_W-1:0]      r_out_byte;
    logic                   r_out_last;
    logic                   r_out_ok;
    logic [BYTE_W-1:0]      r_out_len;

    // result of the current byte
    logic                   res_valid;
    logic                   res_ok;
    logic                   res_last;
    logic [BYTE_W-1:0]      res_byte;
    logic [BYTE_W-1:0]      res_len;

    logic                   advance;
    logic                   out_free;

    // helpers
    logic [MSG_W-1:0]       taken_inc;
    logic [MSG_W-1:0]       long_len;
    logic [SUM_W-1:0]       short_need;
    logic [SUM_W-1:0]       long_need;
    logic [SUM_W-1:0]       buf_ext;
    logic [BYTE_W:0]        rec_rest;
    logic [SUM_W-1:0]       rec_end;
    logic [MSG_W-1:0]       left_inc;
    logic [BYTE_W-1:0]      url_len;
    logic [BYTE_W-1:0]      sent_inc;
    logic [POS_W-1:0]       pos_dec;

    assign out_free = !r_out_valid || o_out.ready;
    assign advance  = r_in_valid && (!res_valid || out_free);
    assign i_in.ready = !r_in_valid || advance;

    assign taken_inc  = r_taken + MSG_W'(1);
    assign long_len   = {r_msglen[MSG_W-1:BYTE_W], r_in_byte};
    assign buf_ext    = SUM_W'(r_bufsz);
    assign short_need = SUM_W'(SHORT_HDR) + SUM_W'(r_in_byte);
    assign long_need  = SUM_W'(LONG_HDR) + SUM_W'(long_len);
    assign rec_rest   = {1'b0, r_tlen} + {1'b0, r_in_byte};
    assign rec_end    = SUM_W'(taken_inc) + SUM_W'(rec_rest);
    assign left_inc   = r_msglen - taken_inc;
    assign url_len    = r_plen - BYTE_W'(1);
    assign sent_inc   = r_sent + BYTE_W'(1);
    assign pos_dec    = (r_pos != '0) ? (r_pos - POS_W'(1)) : r_pos;

    always_comb begin
        n_phase   = r_phase;
        n_bufsz   = r_bufsz;
        n_msglen  = r_msglen;
        n_taken   = r_taken;
        n_tnf     = r_tnf;
        n_tlen    = r_tlen;
        n_plen    = r_plen;
        n_pos     = r_pos;
        n_sent    = r_sent;
        res_valid = 1'b0;
        res_ok    = 1'b0;
        res_last  = 1'b1;
        res_byte  = '0;
        res_len   = '0;

        if (r_in_first) begin
            n_bufsz  = r_in_len;
            n_msglen = '0;
            n_taken  = '0;
            n_tnf    = '0;
            n_tlen   = '0;
            n_plen   = '0;
            n_pos    = '0;
            n_sent   = '0;
            if (r_capacity < CAP_MIN || r_in_len < LENGTH_BITS'(4)
                    || r_in_byte != TLV_NDEF) begin
                res_valid = 1'b1;
                n_phase   = PH_DONE;
            end else begin
                n_phase = PH_LEN1;
            end
        end else begin
            case (r_phase)
                PH_LEN1: begin
                    if (r_in_byte == LEN_LONG_MARK) begin
                        if (r_bufsz < LENGTH_BITS'(5)) begin
                            res_valid = 1'b1;
                            n_phase   = PH_DONE;
                        end else begin
                            n_phase = PH_LONG_HI;
                        end
                    end else begin
                        n_msglen = MSG_W'(r_in_byte);
                        n_taken  = '0;
                        // a non-zero short length that fits is below 3 only when 1 or 2
                        if (r_in_byte == '0 || short_need > buf_ext
                                || r_in_byte < BYTE_W'(MIN_RECORD)) begin
                            res_valid = 1'b1;
                            n_phase   = PH_DONE;
                        end else begin
                            n_phase = PH_FLAGS;
                        end
                    end
                end
                PH_LONG_HI: begin
                    n_msglen = {r_in_byte, {(MSG_W-BYTE_W){1'b0}}};
                    n_phase  = PH_LONG_LO;
                end
                PH_LONG_LO: begin
                    n_msglen = long_len;
                    n_taken  = '0;
                    if (long_len == '0 || long_need > buf_ext
                            || long_len < MSG_W'(MIN_RECORD)) begin
                        res_valid = 1'b1;
                        n_phase   = PH_DONE;
                    end else begin
                        n_phase = PH_FLAGS;
                    end
                end
                PH_FLAGS: begin
                    n_taken = taken_inc;
                    n_tnf   = r_in_byte[2:0];
                    n_phase = PH_TLEN;
                end
                PH_TLEN: begin
                    n_taken = taken_inc;
                    n_tlen  = r_in_byte;
                    n_phase = PH_PLEN;
                end
                PH_PLEN: begin
                    n_taken = taken_inc;
                    n_plen  = r_in_byte;
                    if (rec_end > SUM_W'(r_msglen)) begin
                        res_valid = 1'b1;
                        n_phase   = PH_DONE;
                    end else if ((r_tnf & TNF_MASK) == TNF_WELL_KNOWN
                            && r_tlen == BYTE_W'(1) && r_in_byte >= BYTE_W'(2)) begin
                        n_phase = PH_TYPE;
                    end else if (rec_rest == '0) begin
                        if (left_inc < MSG_W'(MIN_RECORD)) begin
                            res_valid = 1'b1;
                            n_phase   = PH_DONE;
                        end else begin
                            n_phase = PH_FLAGS;
                        end
                    end else begin
                        n_pos   = POS_W'(rec_rest);
                        n_phase = PH_SKIP;
                    end
                end
                PH_TYPE: begin
                    n_taken = taken_inc;
                    if (r_in_byte == TYPE_URI) begin
                        if (CAP_W'(url_len) >= r_capacity) begin
                            res_valid = 1'b1;
                            n_phase   = PH_DONE;
                        end else begin
                            n_phase = PH_CODE;
                        end
                    end else begin
                        n_pos   = POS_W'(r_plen);
                        n_phase = PH_SKIP;
                    end
                end
                PH_CODE: begin
                    // uri identifier code, not part of the url
                    n_taken = taken_inc;
                    n_sent  = '0;
                    n_phase = PH_URL;
                end
                PH_URL: begin
                    n_taken   = taken_inc;
                    n_sent    = sent_inc;
                    res_valid = 1'b1;
                    res_ok    = 1'b1;
                    res_byte  = r_in_byte;
                    if (sent_inc >= url_len) begin
                        res_last = 1'b1;
                        res_len  = url_len;
                        n_phase  = PH_DONE;
                    end else begin
                        res_last = 1'b0;
                    end
                end
                PH_SKIP: begin
                    n_taken = taken_inc;
                    n_pos   = pos_dec;
                    if (pos_dec == '0) begin
                        if (left_inc < MSG_W'(MIN_RECORD)) begin
                            res_valid = 1'b1;
                            n_phase   = PH_DONE;
                        end else begin
                            n_phase = PH_FLAGS;
                        end
                    end
                end
                default: begin
                    // waiting for a first byte or after a decision: ignore
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity  <= CAP_RESET;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_WAIT;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (advance) begin
                r_phase <= n_phase;
            end
            if (advance && res_valid) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte  <= i_in.data_byte;
            r_in_first <= i_in.first_byte;
            r_in_len   <= i_in.buffer_length[LENGTH_BITS-1:0];
        end
        if (advance) begin
            r_bufsz  <= n_bufsz;
            r_msglen <= n_msglen;
            r_taken  <= n_taken;
            r_tnf    <= n_tnf;
            r_tlen   <= n_tlen;
            r_plen   <= n_plen;
            r_pos    <= n_pos;
            r_sent   <= n_sent;
        end
        if (advance && res_valid) begin
            r_out_byte <= res_byte;
            r_out_last <= res_last;
            r_out_ok   <= res_ok;
            r_out_len  <= res_len;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.url_byte   = r_out_byte;
    assign o_out.last       = r_out_last;
    assign o_out.ok         = r_out_ok;
    assign o_out.url_length = r_out_len;

endmodule

`default_nettype wire

### hw/rtl/nure_checker.sv
// port-level checks for the ndef uri record extractor, bound to the core
// depends on nure_pkg and on the core's channel ports
`default_nettype none

module nure_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_out_valid,
    input wire logic                        i_out_ready,
    input wire logic [nure_pkg::BYTE_W-1:0] i_out_url_byte,
    input wire logic                        i_out_last,
    input wire logic                        i_out_ok,
    input wire logic [nure_pkg::BYTE_W-1:0] i_out_url_length
);
    import nure_pkg::*;

    // an error word is a single terminating word with zero payload
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ok) |->
            (i_out_last && i_out_url_byte == '0 && i_out_url_length == '0))
        else $error("error word with nonzero payload or without last");

    // length only on the final url byte
    a_mid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ok && !i_out_last) |-> (i_out_url_length == '0))
        else $error("url length shown before the final url byte");

    // a url always holds at least one byte
    a_last_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ok && i_out_last) |-> (i_out_url_length != '0))
        else $error("final url byte with zero length");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_url_byte) && $stable(i_out_last)
             && $stable(i_out_ok) && $stable(i_out_url_length)))
        else $error("output word changed while stalled");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

endmodule

bind ndef_uri_record_extractor_core nure_checker u_nure_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_url_byte   (o_out.url_byte),
    .i_out_last       (o_out.last),
    .i_out_ok         (o_out.ok),
    .i_out_url_length (o_out.url_length)
);

`default_nettype wire
